// ----- sv/bspc_pkg.sv -----
// ----------------------------------------------------------------------------
// bspc_pkg
// Shared types and constants for the span power-coefficient block.
// ----------------------------------------------------------------------------
`default_nettype none

package bspc_pkg;

    localparam int MAX_DEGREE  = 7;
    localparam int FRAC_BITS   = 16;
    localparam int NSLOT       = MAX_DEGREE + 1;
    localparam int NKNOT       = 2 * MAX_DEGREE;
    localparam int SLOT_W      = $clog2(NSLOT);
    localparam int POLY_DEPTH  = NSLOT * NSLOT;
    localparam int POLY_ADDR_W = 2 * SLOT_W;
    // exact numerator width, units of 2^-(32+FRAC_BITS)
    localparam int NUM_W       = 98;
    localparam int DIV_CNT_W   = $clog2(NUM_W);

    typedef enum logic [1:0] {
        OP_KNOT    = 2'd0,
        OP_POINT   = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } bspc_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW_L,
        ST_ROW_R,
        ST_RD,
        ST_LOAD,
        ST_MUL,
        ST_ACC,
        ST_DIVSET,
        ST_DIV,
        ST_WR,
        ST_EMIT_RD,
        ST_EMIT
    } bspc_state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [3:0]         element_index;
        logic signed [31:0] value;
    } bspc_item_t;

    typedef struct packed {
        logic signed [63:0] coefficient;
        logic [2:0]         term_power;
        logic               last;
        logic               error;
    } bspc_result_t;

endpackage

`default_nettype wire

// ----- sv/bspc_ram.sv -----
// ----------------------------------------------------------------------------
// bspc_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bspc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ----- sv/bspline_segment_power_coefficients.sv -----
// ----------------------------------------------------------------------------
// bspline_segment_power_coefficients
// De Boor triangle run symbolically in t; emits the span's power coefficients.
// ----------------------------------------------------------------------------
// Load beats (knot or point) are taken one per cycle while idle. A compute beat runs p stages
// on one shared 33x33 multiplier and one restoring divider that retires one
// quotient bit per cycle, then emits p+1 result beats. The input is not ready
// from a compute beat until its last result beat is taken. A zero knot difference
// zeroes that partial polynomial and raises error on every result of the run.
`default_nettype none

module bspline_segment_power_coefficients (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_wdata,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire bspc_pkg::bspc_item_t  item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output bspc_pkg::bspc_result_t     result
);

    import bspc_pkg::*;

    bspc_state_t state_reg, state_next;

    logic [2:0]               degree_reg;
    logic [SLOT_W-1:0]        p_reg, r_reg, j_reg, s_reg;
    logic                     err_reg;
    logic [1:0]               k_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;

    logic signed [31:0]       knot_reg  [NKNOT];
    logic signed [31:0]       point_reg [NSLOT];

    logic signed [31:0]       lk_reg, rk_reg;
    logic signed [32:0]       den_reg;
    logic [31:0]              dv_reg;
    logic [31:0]              rem_reg;
    logic [NUM_W-1:0]         m_reg;
    logic                     neg_reg;
    logic signed [NUM_W-1:0]  acc_reg, prod_reg;
    logic                     sub_reg;
    logic signed [63:0]       cs_reg, ps_reg, cm_reg, pm_reg;

    logic                     item_acc;
    logic                     ram_we;
    logic [POLY_ADDR_W-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [63:0]              ram_wdata, ram_rdata_a, ram_rdata_b;

    logic [3:0]               rk_idx;
    logic signed [32:0]       mul_a, mul_b;
    logic signed [65:0]       mul_p;
    logic [32:0]              rem_sh;
    logic signed [63:0]       sat_q;
    logic                     row_done, stage_done;

    assign item_acc   = item_valid && item_ready;
    assign rk_idx     = 4'(j_reg) + 4'(p_reg) - 4'(r_reg);
    assign row_done   = (s_reg == r_reg);
    assign stage_done = (j_reg == r_reg);

    // partial polynomial store, row j column s at {j, s}
    bspc_ram #(
        .WIDTH (64),
        .DEPTH (POLY_DEPTH)
    ) u_poly (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // shared multiplier operands: knot times one 32-bit half of a coefficient
    always_comb
    begin
        mul_a = (k_reg[1] == 1'b0) ? {rk_reg[31], rk_reg} : {lk_reg[31], lk_reg};
        unique case (k_reg)
            2'd0:    mul_b = {1'b0, pm_reg[31:0]};
            2'd1:    mul_b = {pm_reg[63], pm_reg[63:32]};
            2'd2:    mul_b = {1'b0, cm_reg[31:0]};
            default: mul_b = {cm_reg[63], cm_reg[63:32]};
        endcase
        mul_p = mul_a * mul_b;
    end

    // divider step
    assign rem_sh = {rem_reg, m_reg[NUM_W-1]};

    // rounding result sign and saturation
    always_comb
    begin
        if (neg_reg ^ den_reg[32])
        begin
            if ((|m_reg[NUM_W-1:64]) || (m_reg[63] && (|m_reg[62:0])))
            begin
                sat_q = {1'b1, 63'd0};
            end
            else
            begin
                sat_q = -$signed(m_reg[63:0]);
            end
        end
        else
        begin
            if (|m_reg[NUM_W-1:63])
            begin
                sat_q = {1'b0, {63{1'b1}}};
            end
            else
            begin
                sat_q = $signed(m_reg[63:0]);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && (item.opcode == OP_COMPUTE))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (j_reg == p_reg)
                begin
                    state_next = (p_reg == '0) ? ST_EMIT_RD : ST_ROW_L;
                end
            end
            ST_ROW_L:   state_next = ST_ROW_R;
            ST_ROW_R:   state_next = ST_RD;
            ST_RD:      state_next = ST_LOAD;
            ST_LOAD:    state_next = (den_reg == '0) ? ST_WR : ST_MUL;
            ST_MUL:     state_next = ST_ACC;
            ST_ACC:     state_next = (k_reg == 2'd3) ? ST_DIVSET : ST_MUL;
            ST_DIVSET:  state_next = ST_DIV;
            ST_DIV:     state_next = (cnt_reg == '0) ? ST_WR : ST_DIV;
            ST_WR:
            begin
                if (!row_done)
                begin
                    state_next = ST_RD;
                end
                else if (stage_done && (r_reg == p_reg))
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    state_next = ST_ROW_L;
                end
            end
            ST_EMIT_RD: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (result_ready)
                begin
                    state_next = (s_reg == p_reg) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // handshake and store controls
    always_comb
    begin
        item_ready   = (state_reg == ST_IDLE);
        result_valid = (state_reg == ST_EMIT);
        ram_we       = 1'b0;
        ram_waddr    = {j_reg, s_reg};
        ram_wdata    = sat_q;
        ram_raddr_a  = {j_reg, s_reg};
        ram_raddr_b  = {j_reg - SLOT_W'(1), s_reg};
        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = {j_reg, SLOT_W'(0)};
                ram_wdata = 64'(point_reg[j_reg]) <<< (32 - FRAC_BITS);
            end
            ST_WR:
            begin
                ram_we = 1'b1;
            end
            ST_EMIT_RD, ST_EMIT:
            begin
                ram_raddr_a = {p_reg, s_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
        result.coefficient = ram_rdata_a;
        result.term_power  = 3'(p_reg - s_reg);
        result.last        = (s_reg == p_reg);
        result.error       = err_reg;
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            degree_reg <= 3'd3;
            p_reg      <= '0;
            r_reg      <= '0;
            j_reg      <= '0;
            s_reg      <= '0;
            k_reg      <= '0;
            cnt_reg    <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                degree_reg <= cfg_wdata;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    p_reg   <= SLOT_W'(degree_reg);
                    j_reg   <= '0;
                    s_reg   <= '0;
                    err_reg <= 1'b0;
                end
                ST_INIT:
                begin
                    r_reg <= SLOT_W'(1);
                    if (j_reg == p_reg)
                    begin
                        j_reg <= p_reg;
                    end
                    else
                    begin
                        j_reg <= j_reg + SLOT_W'(1);
                    end
                end
                ST_ROW_R:
                begin
                    s_reg <= '0;
                end
                ST_LOAD:
                begin
                    k_reg <= '0;
                    if (den_reg == '0)
                    begin
                        err_reg <= 1'b1;
                    end
                end
                ST_ACC:
                begin
                    k_reg <= k_reg + 2'd1;
                end
                ST_DIVSET:
                begin
                    cnt_reg <= DIV_CNT_W'(NUM_W - 1);
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                end
                ST_WR:
                begin
                    if (!row_done)
                    begin
                        s_reg <= s_reg + SLOT_W'(1);
                    end
                    else if (stage_done && (r_reg == p_reg))
                    begin
                        s_reg <= '0;
                    end
                    else if (stage_done)
                    begin
                        r_reg <= r_reg + SLOT_W'(1);
                        j_reg <= p_reg;
                    end
                    else
                    begin
                        j_reg <= j_reg - SLOT_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (result_ready && (s_reg != p_reg))
                    begin
                        s_reg <= s_reg + SLOT_W'(1);
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    // knot and point windows
    always_ff @(posedge clk)
    begin
        if (item_acc && (item.opcode == OP_KNOT) && (item.element_index < 4'(NKNOT)))
        begin
            knot_reg[item.element_index] <= item.value;
        end
        if (item_acc && (item.opcode == OP_POINT) && (item.element_index < 4'(NSLOT)))
        begin
            point_reg[item.element_index[SLOT_W-1:0]] <= item.value;
        end
    end

    // arithmetic datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_ROW_L:
            begin
                lk_reg <= knot_reg[j_reg - SLOT_W'(1)];
            end
            ST_ROW_R:
            begin
                rk_reg  <= knot_reg[rk_idx];
                den_reg <= 33'(knot_reg[rk_idx]) - 33'(lk_reg);
                cm_reg  <= '0;
                pm_reg  <= '0;
            end
            ST_LOAD:
            begin
                cs_reg  <= (s_reg < r_reg) ? $signed(ram_rdata_a) : 64'sd0;
                ps_reg  <= (s_reg < r_reg) ? $signed(ram_rdata_b) : 64'sd0;
                acc_reg <= ((s_reg < r_reg) ?
                           (NUM_W'($signed(ram_rdata_a)) - NUM_W'($signed(ram_rdata_b)))
                           : '0) <<< FRAC_BITS;
                dv_reg  <= den_reg[32] ? 32'(-den_reg) : den_reg[31:0];
                m_reg   <= '0;
                neg_reg <= 1'b0;
            end
            ST_MUL:
            begin
                prod_reg <= k_reg[0] ? (NUM_W'(mul_p) <<< 32) : NUM_W'(mul_p);
                sub_reg  <= k_reg[1];
            end
            ST_ACC:
            begin
                acc_reg <= sub_reg ? (acc_reg - prod_reg) : (acc_reg + prod_reg);
            end
            ST_DIVSET:
            begin
                neg_reg <= acc_reg[NUM_W-1];
                m_reg   <= (acc_reg[NUM_W-1] ? NUM_W'(-acc_reg) : NUM_W'(acc_reg))
                           + NUM_W'(dv_reg >> 1);
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, dv_reg})
                begin
                    rem_reg <= 32'(rem_sh - {1'b0, dv_reg});
                    m_reg   <= {m_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh[31:0];
                    m_reg   <= {m_reg[NUM_W-2:0], 1'b0};
                end
            end
            ST_WR:
            begin
                cm_reg <= cs_reg;
                pm_reg <= ps_reg;
            end
            default:
            begin
                sub_reg <= sub_reg;
            end
        endcase
    end

    // checks
    a_emit_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !item_ready)
        else $error("result beat while accepting items");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && result.last) |=> item_ready)
        else $error("block not idle after last result beat");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < dv_reg))
        else $error("divider remainder out of range");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (den_reg != '0))
        else $error("multiply with zero knot difference");

endmodule

`default_nettype wire

// ----- tb/sv/tb_bspline_segment_power_coefficients.sv -----
// ----------------------------------------------------------------------------
// tb_bspline_segment_power_coefficients
// Loads knot and point windows, runs span computes at every degree and checks
// each coefficient beat against a bit-exact de Boor power-basis predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bspline_segment_power_coefficients;
    import bspc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 480;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PERCENT = 12;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_wdata;
    logic         item_valid;
    logic         item_ready;
    bspc_item_t   item;
    logic         result_valid;
    logic         result_ready;
    bspc_result_t result;

    // predictor state
    logic signed [31:0] knot_win [0:NKNOT-1];
    logic signed [31:0] point_win [0:NSLOT-1];
    logic [2:0]         span_degree;
    bspc_result_t       coeff_expect_q [$];

    int  mismatch_cnt;
    int  items_sent;
    bit  idle_en;
    bit  hold_req;

    bspline_segment_power_coefficients uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_000_000_000;
        $display("FAIL");
        $finish;
    end

    // rounded division, ties away from zero, saturated to 64 bits
    function automatic logic signed [63:0] div_round_sat(logic signed [127:0] num,
                                                         logic signed [63:0] den);
        logic         neg;
        logic [127:0] mag;
        logic [127:0] dv;
        logic [127:0] quo;
        neg = num < 0;
        mag = neg ? -num : num;
        dv  = den < 0 ? -{{64{den[63]}}, den} : {64'd0, den};
        mag = mag + (dv >> 1);
        quo = mag / dv;
        if (neg != (den < 0))
        begin
            if (quo > (128'd1 << 63))
                return {1'b1, 63'd0};
            return -quo[63:0];
        end
        if (quo > {65'd0, {63{1'b1}}})
            return {1'b0, {63{1'b1}}};
        return quo[63:0];
    endfunction

    // symbolic de Boor triangle, queues the p+1 expected coefficient beats
    task automatic predict_span_coeffs();
        logic signed [63:0]  poly [0:NSLOT-1][0:NSLOT-1];
        logic signed [63:0]  nxt [0:NSLOT-1];
        logic signed [127:0] num, lk, rk, cs, ps, cm, pm;
        logic signed [63:0]  den;
        bspc_result_t        res;
        bit                  err;
        int                  p;
        err = 0;
        p = span_degree;
        for (int j = 0; j <= p; j++)
        begin
            for (int s = 0; s < NSLOT; s++)
                poly[j][s] = '0;
            poly[j][0] = 64'(point_win[j]) <<< (32 - FRAC_BITS);
        end
        for (int r = 1; r <= p; r++)
        begin
            for (int j = p; j >= r; j--)
            begin
                lk  = knot_win[j-1];
                rk  = knot_win[j+p-r];
                den = 64'(knot_win[j+p-r]) - 64'(knot_win[j-1]);
                for (int s = 0; s < NSLOT; s++)
                    nxt[s] = '0;
                if (den == 0)
                    err = 1;
                else
                begin
                    for (int s = 0; s <= r; s++)
                    begin
                        cs  = s < r ? poly[j][s] : 64'sd0;
                        ps  = s < r ? poly[j-1][s] : 64'sd0;
                        cm  = s > 0 ? poly[j][s-1] : 64'sd0;
                        pm  = s > 0 ? poly[j-1][s-1] : 64'sd0;
                        num = ((cs - ps) <<< FRAC_BITS) + rk * pm - lk * cm;
                        nxt[s] = div_round_sat(num, den);
                    end
                end
                for (int s = 0; s < NSLOT; s++)
                    poly[j][s] = nxt[s];
            end
        end
        for (int s = 0; s <= p; s++)
        begin
            res.coefficient = poly[p][s];
            res.term_power  = 3'(p - s);
            res.last        = (s == p);
            res.error       = err;
            coeff_expect_q  = {coeff_expect_q, res};
        end
    endtask

    task automatic apply_item(bspc_item_t it);
        unique case (it.opcode)
            OP_KNOT:
                if (it.element_index < NKNOT)
                    knot_win[it.element_index] = it.value;
            OP_POINT:
                if (it.element_index <= MAX_DEGREE)
                    point_win[it.element_index] = it.value;
            OP_COMPUTE:
                predict_span_coeffs();
            default: ;
        endcase
    endtask

    // input monitor and result checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (coeff_expect_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result beat: coef %0d pow %0d last %0d err %0d",
                                 result.coefficient, result.term_power, result.last,
                                 result.error);
                end
                else
                begin
                    bspc_result_t exp_r;
                    exp_r = coeff_expect_q.pop_front();
                    if (result.coefficient !== exp_r.coefficient ||
                        result.term_power !== exp_r.term_power ||
                        result.last !== exp_r.last || result.error !== exp_r.error)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $write("mismatch: exp coef %0d pow %0d last %0d err %0d",
                                   exp_r.coefficient, exp_r.term_power, exp_r.last,
                                   exp_r.error);
                            $display(" / got coef %0d pow %0d last %0d err %0d",
                                     result.coefficient, result.term_power,
                                     result.last, result.error);
                        end
                    end
                end
            end
            if (item_valid && item_ready)
                apply_item(item);
        end
    end

    // receiver ready with random stalls and a long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (idle_en)
                result_ready <= ($urandom_range(99) >= IDLE_PERCENT);
            else
                result_ready <= 1'b1;
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_item(bspc_op_t op, logic [3:0] idx, logic signed [31:0] val);
        bspc_item_t it;
        it.opcode        = op;
        it.element_index = idx;
        it.value         = val;
        while (idle_en && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (coeff_expect_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // degree write, only with the block idle
    task automatic set_degree(logic [2:0] deg);
        drain();
        cfg_we      <= 1'b1;
        cfg_wdata   <= deg;
        span_degree = deg;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(5))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return $urandom;
            default: return $signed(32'($urandom_range(1 << 20))) - (1 << 19);
        endcase
    endfunction

    // ascending knots for the current degree, occasionally a repeated one
    task automatic load_span();
        logic signed [31:0] k;
        int                 p;
        p = span_degree;
        k = $signed(32'($urandom_range(1 << 21))) - (1 << 20);
        for (int i = 0; i < 2 * p; i++)
        begin
            send_item(OP_KNOT, 4'(i), k);
            if ($urandom_range(29) != 0)
                k = k + 32'($urandom_range(1 << 17, 1));
        end
        for (int i = 0; i <= p; i++)
            send_item(OP_POINT, 4'(i), rand_value());
        send_item(OP_COMPUTE, 4'($urandom_range(15)), $urandom);
    endtask

    task automatic test_directed();
        // fill both windows so no compute reads an unwritten slot
        for (int i = 0; i < NKNOT; i++)
            send_item(OP_KNOT, 4'(i), 32'sh10000 * i - 32'sh30000);
        for (int i = 0; i < NSLOT; i++)
            send_item(OP_POINT, 4'(i), 32'sh8000 * (i + 1));
        send_item(OP_COMPUTE, 4'd0, 32'sd0);
        // ignored beats: unused opcode, slots out of range
        send_item(OP_NONE, 4'd2, 32'sh7fffffff);
        send_item(OP_KNOT, 4'd14, 32'sd0);
        send_item(OP_KNOT, 4'd15, 32'sd0);
        send_item(OP_POINT, 4'd8, 32'sh80000000);
        send_item(OP_POINT, 4'd15, 32'sh7fffffff);
        send_item(OP_COMPUTE, 4'd15, 32'shffffffff);
        // extreme points and widest knot spread
        send_item(OP_POINT, 4'd0, 32'sh7fffffff);
        send_item(OP_POINT, 4'd1, 32'sh80000000);
        send_item(OP_KNOT, 4'd0, 32'sh80000000);
        send_item(OP_KNOT, 4'd5, 32'sh7fffffff);
        send_item(OP_COMPUTE, 4'd7, 32'sd0);
        // tiny knot spacing drives the coefficients into saturation
        send_item(OP_KNOT, 4'd2, 32'sd1);
        send_item(OP_KNOT, 4'd3, 32'sd2);
        send_item(OP_COMPUTE, 4'd0, 32'sd0);
        // zero knot difference
        send_item(OP_KNOT, 4'd3, 32'sd1);
        send_item(OP_COMPUTE, 4'd0, 32'sd0);
        // degree extremes
        set_degree(3'd0);
        send_item(OP_COMPUTE, 4'd0, 32'sd0);
        set_degree(3'd1);
        send_item(OP_COMPUTE, 4'd0, 32'sd0);
        set_degree(3'd7);
        send_item(OP_COMPUTE, 4'd0, 32'sd0);
    endtask

    // well-formed spans with random content, mixed with noise beats
    task automatic test_random_spans();
        int phase;
        int start;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            // large degrees are slow, so they get few phases
            if (phase % 5 == 4)
                set_degree(3'($urandom_range(7, 5)));
            else if (phase % 7 == 6)
                set_degree(3'd0);
            else
                set_degree(3'($urandom_range(4, 1)));
            idle_en = (phase != 2);
            start = items_sent;
            while (items_sent - start < 40)
            begin
                if ($urandom_range(3) != 0)
                    load_span();
                else
                begin
                    repeat ($urandom_range(6, 1))
                        send_item(bspc_op_t'($urandom_range(3)), 4'($urandom_range(15)),
                                  rand_value());
                end
            end
            phase++;
        end
        idle_en = 1;
    endtask

    // receiver stalls for a long time while computes keep coming
    task automatic test_backpressure();
        set_degree(3'd2);
        hold_req = 1;
        load_span();
        repeat (3)
            send_item(OP_COMPUTE, 4'd0, 32'sd0);
        load_span();
    endtask

    initial
    begin
        mismatch_cnt = 0;
        items_sent   = 0;
        idle_en      = 1;
        hold_req     = 0;
        span_degree  = 3'd3;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 3'd0;
        item_valid   = 1'b0;
        item         = '0;
        for (int i = 0; i < NKNOT; i++)
            knot_win[i] = '0;
        for (int i = 0; i < NSLOT; i++)
            point_win[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_spans();

        drain();
        if (mismatch_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
